FILE: hw/rtl/ccrc_pkg.sv
// Shared constants, configuration types and CRC helper functions for the CRC-16 engine.
package ccrc_pkg;

    localparam int unsigned CRC_W     = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POLY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_OUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_IN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_OUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESIDUE  = 3'd5;

    localparam logic [CRC_W-1:0] RST_POLY    = 16'h1021;
    localparam logic [CRC_W-1:0] RST_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0] RST_XOR_OUT = 16'h0000;
    localparam logic [CRC_W-1:0] RST_RESIDUE = 16'h0000;
    localparam logic [CRC_W-1:0] CRC_TOP_BIT = 16'h8000;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init_value;
        logic [CRC_W-1:0] xor_out;
        logic             refl_in;
        logic             refl_out;
        logic [CRC_W-1:0] residue;
        logic             init_load;
        logic [CRC_W-1:0] init_load_value;
    } t_cfg;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // Eight MSB-first shift steps after the byte is folded into the high byte.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_TOP_BIT) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/ccrc_cfg_regs.sv
// Configuration register file of the CRC-16 engine.
module ccrc_cfg_regs import ccrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] r_init;
    logic [CRC_W-1:0] r_xor_out;
    logic             r_refl_in;
    logic             r_refl_out;
    logic [CRC_W-1:0] r_residue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= RST_POLY;
            r_init     <= RST_INIT;
            r_xor_out  <= RST_XOR_OUT;
            r_refl_in  <= 1'b0;
            r_refl_out <= 1'b0;
            r_residue  <= RST_RESIDUE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLY:     r_poly     <= i_cfg_data[CRC_W-1:0];
                CFG_INIT:     r_init     <= i_cfg_data[CRC_W-1:0];
                CFG_XOR_OUT:  r_xor_out  <= i_cfg_data[CRC_W-1:0];
                CFG_REFL_IN:  r_refl_in  <= i_cfg_data[0];
                CFG_REFL_OUT: r_refl_out <= i_cfg_data[0];
                CFG_RESIDUE:  r_residue  <= i_cfg_data[CRC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.poly            = r_poly;
        o_cfg.init_value      = r_init;
        o_cfg.xor_out         = r_xor_out;
        o_cfg.refl_in         = r_refl_in;
        o_cfg.refl_out        = r_refl_out;
        o_cfg.residue         = r_residue;
        o_cfg.init_load       = i_cfg_we && (i_cfg_idx == CFG_INIT);
        o_cfg.init_load_value = i_cfg_data[CRC_W-1:0];
    end

endmodule

FILE: hw/rtl/ccrc_core.sv
// Input register, CRC state register, byte update logic and result register.
module ccrc_core import ccrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_is_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CRC_W-1:0]  o_crc_value,
    output logic              o_final_res,
    output logic              o_residue_ok
);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_last;
    logic [CRC_W-1:0]  r_crc;
    logic              r_out_vld;
    logic [CRC_W-1:0]  r_out_crc;
    logic              r_out_final;
    logic              r_out_res_ok;

    logic              out_free;
    logic              in_adv;
    logic              in_take;
    logic [BYTE_W-1:0] data_in;
    logic [CRC_W-1:0]  crc_step;
    logic [CRC_W-1:0]  crc_fin;
    logic [CRC_W-1:0]  n_crc;
    logic [CRC_W-1:0]  n_out_crc;
    logic              n_out_res_ok;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign in_adv     = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        data_in  = i_cfg.refl_in ? rev8(r_in_data) : r_in_data;
        crc_step = crc_byte(r_crc, data_in, i_cfg.poly);
        crc_fin  = crc_step ^ i_cfg.xor_out;
        if (r_in_last) begin
            n_out_crc    = i_cfg.refl_out ? rev16(crc_fin) : crc_fin;
            n_out_res_ok = ((n_out_crc ^ i_cfg.xor_out) == i_cfg.residue);
            n_crc        = i_cfg.init_value;
        end else begin
            n_out_crc    = crc_step;
            n_out_res_ok = 1'b0;
            n_crc        = crc_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_crc     <= RST_INIT;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (in_adv) begin
                r_in_vld <= 1'b0;
            end
            if (in_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.init_load) begin
                r_crc <= i_cfg.init_load_value;
            end else if (in_adv) begin
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_is_last;
        end
        if (in_adv) begin
            r_out_crc    <= n_out_crc;
            r_out_final  <= r_in_last;
            r_out_res_ok <= n_out_res_ok;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_crc_value  = r_out_crc;
    assign o_final_res  = r_out_final;
    assign o_residue_ok = r_out_res_ok;

    a_nonfinal_no_res_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_final |-> !r_out_res_ok)
        else $error("residue flag set on a running result");

    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv && r_in_last && !i_cfg.init_load |=> r_crc == $past(i_cfg.init_value))
        else $error("CRC register not reloaded after last byte");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_out_vld)
        else $error("advanced item did not reach the result register");

    a_blocked_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !out_free |=> r_in_vld && $stable(r_in_data) && $stable(r_in_last))
        else $error("blocked item lost from the input register");

endmodule

FILE: hw/rtl/configurable_crc16_engine_top.sv
// Top level of the configurable CRC-16 engine.
//
// The input channel carries one message byte per item together with a flag
// that marks the last byte of the message; every message has at least one byte.
// For each item the result channel returns the running CRC register, or, on
// the last byte, the finished CRC after the output XOR and optional reflection,
// with a final flag and a residue-match flag.
// An item is held in the input register and is then folded into the CRC
// register by an eight-step combinational shift network, landing in the result
// register; a stall on the result channel can hold it in the input register.
// Throughput is one item per clock cycle while the receiver does not stall,
// bounded by the CRC register update loop.
// A synchronous active-low reset clears both valid flags, loads the reset
// configuration and sets the CRC register to the reset initial value.
// When the receiver stalls, the result register holds its item, the input
// register keeps one more item, and the input stall rises after that.
// Configuration is written through a plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce;
// a write to the initial value also reloads the CRC register.
module configurable_crc16_engine_top import ccrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_is_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CRC_W-1:0]     o_crc_value,
    output logic                 o_final_res,
    output logic                 o_residue_ok
);

    t_cfg cfg;

    ccrc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ccrc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_is_last    (i_is_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_crc_value  (o_crc_value),
        .o_final_res  (o_final_res),
        .o_residue_ok (o_residue_ok)
    );

endmodule
